// ----- sv/text_case_converter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Text case converter assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CASE_CONVERTER_CORE_DEFINES_SVH
`define TEXT_CASE_CONVERTER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Text case converter package
// Widths, register indexes, case modes and character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

   // Width of the byte position counter and of the forced length register.
   localparam int POS_BITS = 16;
   localparam int LEN_BITS = 16;
   localparam int CMP_BITS = (POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS;
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // Configuration register indexes.
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CASE_MODE    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORCE_ENABLE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORCED_LEN   = 2'd2;

   // Punctuation that ends a sentence, and the offset between the two letter cases.
   localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
   localparam logic [7:0] CHAR_BANG     = 8'h21;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CASE_DELTA    = 8'h20;

   typedef enum logic [2:0] {
      MODE_NONE       = 3'd0,
      MODE_LOWER      = 3'd1,
      MODE_UPPER      = 3'd2,
      MODE_CAPITALIZE = 3'd3,
      MODE_TITLE      = 3'd4,
      MODE_SENTENCE   = 3'd5
   } case_mode_type;

   // Recased byte together with the updated capital flag.
   typedef struct packed {
      logic [7:0] char_out;
      logic       pending;
   } recase_type;

   function automatic logic is_upper(input logic [7:0] c);
      return (c inside {[8'h41:8'h5A]});
   endfunction

   function automatic logic is_lower(input logic [7:0] c);
      return (c inside {[8'h61:8'h7A]});
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c inside {8'h20, [8'h09:8'h0D]});
   endfunction

   function automatic logic [7:0] to_up(input logic [7:0] c);
      return is_lower(c) ? c - CASE_DELTA : c;
   endfunction

   function automatic logic [7:0] to_low(input logic [7:0] c);
      return is_upper(c) ? c + CASE_DELTA : c;
   endfunction

   // Recase one byte by mode; modes outside the list pass the byte through.
   function automatic recase_type recase(input logic [7:0] c, input logic [2:0] mode,
                                         input logic pending);
      recase_type r;
      logic       letter;
      letter     = is_upper(c) || is_lower(c);
      r.char_out = c;
      r.pending  = pending;
      case (mode)
         MODE_LOWER: begin
            r.char_out = to_low(c);
         end
         MODE_UPPER: begin
            r.char_out = to_up(c);
         end
         MODE_CAPITALIZE: begin
            if (pending && letter) begin
               r.char_out = to_up(c);
               r.pending  = 1'b0;
            end
         end
         MODE_TITLE: begin
            if (is_blank(c)) begin
               r.pending = 1'b1;
            end else if (pending && letter) begin
               r.char_out = to_up(c);
               r.pending  = 1'b0;
            end else begin
               r.char_out = to_low(c);
            end
         end
         MODE_SENTENCE: begin
            if (pending && letter) begin
               r.char_out = to_up(c);
               r.pending  = 1'b0;
            end else begin
               r.char_out = to_low(c);
            end
            if (r.char_out == CHAR_PERIOD || r.char_out == CHAR_BANG ||
                r.char_out == CHAR_QUESTION) begin
               r.pending = 1'b1;
            end
         end
         default: begin
            r.char_out = c;
         end
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- sv/text_case_converter_core.sv -----
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one byte per cycle while rsp_stall is low, set by the single output
// register stage, which takes a new transaction in the cycle its current result is taken.
// Reset (synchronous, active high) clears the result valid, the configuration
// registers, the byte position and sets the pending capital flag.
// ----------------------------------------------------------------------------
// Text case converter core
// Recases a stream of ASCII bytes and optionally truncates or pads the string.
// ----------------------------------------------------------------------------
`default_nettype none

`include "text_case_converter_core_defines.svh"

module text_case_converter_core
   import tcc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // Configuration write port
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [LEN_BITS-1:0]       csr_wdata,
   // Input byte channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_in_byte,
   input  wire logic                      req_in_last,
   // Result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_byte_valid,
   output logic [LEN_BITS-1:0]            rsp_pad_count,
   output logic                           rsp_out_last
);

   logic [2:0]          case_mode_ff;
   logic                force_enable_ff;
   logic [LEN_BITS-1:0] forced_length_ff;

   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic                pending_ff, pending_in;

   logic                valid_ff, valid_in;
   logic [7:0]          byte_ff, byte_in;
   logic                keep_ff, keep_in;
   logic [LEN_BITS-1:0] pad_ff, pad_in;
   logic                last_ff, last_in;

   logic                req_accept;
   logic                forcing;
   logic [CMP_BITS-1:0] pos_wide;
   logic [CMP_BITS-1:0] counted_wide;
   logic [CMP_BITS-1:0] forced_wide;
   logic [POS_BITS-1:0] counted;
   recase_type          recased;

   // The output register frees up when its result is taken.
   assign req_stall  = valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         case_mode_ff     <= MODE_NONE;
         force_enable_ff  <= 1'b0;
         forced_length_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CASE_MODE:    case_mode_ff     <= csr_wdata[2:0];
            CSR_FORCE_ENABLE: force_enable_ff  <= csr_wdata[0];
            CSR_FORCED_LEN:   forced_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Keep decision, recasing, saturating position and pad count.
   always_comb begin
      forcing      = (case_mode_ff != MODE_NONE) && force_enable_ff;
      pos_wide     = CMP_BITS'(pos_ff);
      forced_wide  = CMP_BITS'(forced_length_ff);
      keep_in      = !forcing || (pos_wide < forced_wide);
      recased      = recase(req_in_byte, case_mode_ff, pending_ff);
      counted      = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
      counted_wide = CMP_BITS'(counted);

      byte_in = keep_in ? recased.char_out : 8'h00;
      last_in = req_in_last;
      if (req_in_last && forcing && (forced_wide > counted_wide)) begin
         pad_in = LEN_BITS'(forced_wide - counted_wide);
      end else begin
         pad_in = '0;
      end

      if (req_in_last) begin
         pos_in     = '0;
         pending_in = 1'b1;
      end else begin
         pos_in     = counted;
         pending_in = keep_in ? recased.pending : pending_ff;
      end
   end

   // String state advances once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         pending_ff <= 1'b1;
      end else if (req_accept) begin
         pos_ff     <= pos_in;
         pending_ff <= pending_in;
      end
   end

   // Result register: loads on accept, empties when taken.
   always_comb begin
      if (req_accept) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         byte_ff <= byte_in;
         keep_ff <= keep_in;
         pad_ff  <= pad_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = keep_ff;
   assign rsp_pad_count  = pad_ff;
   assign rsp_out_last   = last_ff;

   // Padding is only reported on the result that ends the string.
   `TCC_ASSERT_SAME(a_pad_only_last, valid_ff && (pad_ff != '0), last_ff,
                    "pad count reported on a result that is not last")

   // A dropped byte carries a zero value.
   `TCC_ASSERT_SAME(a_drop_zero, valid_ff && !keep_ff, byte_ff == 8'h00,
                    "dropped byte has a nonzero value")

   // The string state returns to its start after a last transaction.
   `TCC_ASSERT_NEXT(a_state_restart, req_accept && req_in_last,
                    (pos_ff == '0) && pending_ff,
                    "string state not restarted after last byte")

   // An accepted transaction always leaves a result waiting.
   `TCC_ASSERT_NEXT(a_accept_fills, req_accept, valid_ff,
                    "accepted transaction produced no result")

endmodule

`default_nettype wire
